// File: hw/rtl/flywheel_shot_drop_detector_top_defines.svh
// Assertion macros shared by the flywheel shot-drop detector RTL.
`ifndef FLYWHEEL_SHOT_DROP_DETECTOR_TOP_DEFINES_SVH
`define FLYWHEEL_SHOT_DROP_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define FSDD_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fsdd: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define FSDD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fsdd: next-cycle check failed");

`endif

// File: hw/rtl/fsdd_pkg.sv
// Types and constants of the flywheel shot-drop detector.
`timescale 1ns / 1ps
package fsdd_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int MAG_W       = SPEED_WIDTH + 1;   // |a| + |b|, speed units
    localparam int FRAC_W      = 15;                // magnitude to baseline scale
    localparam int VAL_W       = MAG_W + FRAC_W;    // baseline, 15 fractional bits
    localparam int DROP_W      = VAL_W + 1;         // signed drop
    localparam int GAIN_W      = 17;
    localparam int CFG_W       = 17;
    localparam int COUNT_W     = 32;

    localparam logic [GAIN_W-1:0] Q16_ONE = 17'h10000;

    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t CFG_RISE_GAIN    = 3'd0;
    localparam cfg_index_t CFG_FALL_GAIN    = 3'd1;
    localparam cfg_index_t CFG_FIRE_THRESH  = 3'd2;
    localparam cfg_index_t CFG_MIN_SLOPE    = 3'd3;
    localparam cfg_index_t CFG_RECOVER_FRAC = 3'd4;
    localparam cfg_index_t CFG_SAFE_THRESH  = 3'd5;
    localparam cfg_index_t CFG_COOLDOWN     = 3'd6;
    localparam cfg_index_t CFG_TIMEOUT      = 3'd7;

    typedef struct packed {
        logic signed [SPEED_WIDTH-1:0] speed_a;
        logic signed [SPEED_WIDTH-1:0] speed_b;
    } fsdd_in_t;

    typedef struct packed {
        logic               shot_detected;
        logic [COUNT_W-1:0] shot_count;
    } fsdd_out_t;

endpackage

// File: hw/rtl/flywheel_shot_drop_detector_top.sv
// Flywheel shot-drop detector: magnitude sum, baseline tracking and shot counting.
`timescale 1ns / 1ps
// Usage
//   s_valid/s_ready/s_item carry one item: two signed speed samples.
//   m_valid/m_ready/m_item return one item per input item: a shot flag for
//   that sample and the running shot total (wraps at 2^32).
//   cfg_wr_en/cfg_index/cfg_wdata write one setting per cycle; write only
//   while no item is in flight.
// Timing
//   An accepted item is taken into the input register and then into the
//   result register, which drives m_item. One item per cycle is sustained
//   while m_ready stays high: the input register takes |a| + |b|, and the
//   single update stage (one baseline multiply and one peak-drop multiply,
//   in parallel) writes state and the result register together.
// Stalls
//   If m_ready is low the result register holds; the input register takes
//   one more item and then s_ready drops until the result is taken.
// Reset
//   aresetn low (synchronous) empties both registers, clears the detector
//   state and shot total, and loads the default settings.
`include "flywheel_shot_drop_detector_top_defines.svh"
module flywheel_shot_drop_detector_top
    import fsdd_pkg::*;
#(
    parameter int TICK_WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  cfg_index_t       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  fsdd_in_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output fsdd_out_t        m_item
);

    localparam int CNT_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    // settings
    logic [GAIN_W-1:0] rise_gain_reg, fall_gain_reg;
    logic [15:0]       fire_thresh_reg, min_slope_reg, recover_reg;
    logic [15:0]       safe_thresh_reg, cooldown_reg, timeout_reg;

    // pipeline control
    logic in_v_reg, out_v_reg, advance;

    // input register: summed magnitude
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic signed [MAG_W-1:0] sa_ext, sb_ext;
    logic [MAG_W-1:0] abs_a, abs_b;

    // detector state
    logic                     seeded_reg, seeded_next;
    logic [VAL_W-1:0]         baseline_reg, baseline_next;
    logic [MAG_W-1:0]         prev_reg, prev_next;
    logic signed [DROP_W-1:0] peak_reg, peak_next;
    logic                     armed_reg, armed_next;
    logic [TICK_WIDTH-1:0]    cool_reg, cool_next;
    logic [TICK_WIDTH-1:0]    ticks_reg, ticks_next;
    logic [COUNT_W-1:0]       shots_total_reg, shots_total_next;
    logic                     shot_next;
    fsdd_out_t                out_reg;

    // datapath
    logic [VAL_W-1:0]           val;
    logic [GAIN_W-1:0]          gain_raw, gain;
    logic signed [VAL_W:0]      diff;
    logic signed [VAL_W+18:0]   base_prod;
    logic signed [VAL_W+18:0]   base_step;
    logic [VAL_W-1:0]           base_upd;
    logic signed [DROP_W-1:0]   drop;
    logic signed [MAG_W:0]      slope;
    logic [GAIN_W-1:0]          keep_frac;
    logic signed [DROP_W+15:0]  drop_sh;
    logic signed [DROP_W+17:0]  peak_k;
    logic                       drop_gt_peak, arm_hit, rel_hit, abs_hit, timeout_hit;
    logic [TICK_WIDTH-1:0]      ticks_inc, cd_sat;
    logic [CNT_W-1:0]           cd_wide, tick_max_wide;

    assign advance = in_v_reg && (!out_v_reg || m_ready);
    assign s_ready = !in_v_reg || advance;
    assign m_valid = out_v_reg;
    assign m_item  = out_reg;

    // |a| + |b| on the way in
    always_comb begin
        sa_ext   = MAG_W'(s_item.speed_a);
        sb_ext   = MAG_W'(s_item.speed_b);
        abs_a    = sa_ext[MAG_W-1] ? MAG_W'(-sa_ext) : MAG_W'(sa_ext);
        abs_b    = sb_ext[MAG_W-1] ? MAG_W'(-sb_ext) : MAG_W'(sb_ext);
        mag_next = abs_a + abs_b;
    end

    // baseline: B + floor(g * (V - B) / 2^16)
    always_comb begin
        val       = {mag_reg, {FRAC_W{1'b0}}};
        gain_raw  = (val > baseline_reg) ? rise_gain_reg : fall_gain_reg;
        gain      = (gain_raw > Q16_ONE) ? Q16_ONE : gain_raw;
        diff      = $signed({1'b0, val}) - $signed({1'b0, baseline_reg});
        base_prod = $signed({1'b0, gain}) * diff;
        base_step = base_prod >>> 16;
        base_upd  = baseline_reg + base_step[VAL_W-1:0];
        drop      = $signed({1'b0, base_upd}) - $signed({1'b0, val});
        slope     = $signed({1'b0, prev_reg}) - $signed({1'b0, mag_reg});
    end

    // Peak only grows to the current drop, and then relative recovery cannot
    // fire, so the product uses the stored peak and runs beside the baseline.
    always_comb begin
        keep_frac    = Q16_ONE - {1'b0, recover_reg};
        drop_sh      = $signed({drop, 16'd0});
        peak_k       = peak_reg * $signed({1'b0, keep_frac});
        drop_gt_peak = drop > peak_reg;
        arm_hit      = (drop > $signed(DROP_W'({fire_thresh_reg, {FRAC_W{1'b0}}})))
                    && (slope > $signed(min_slope_reg));
        rel_hit      = !drop_gt_peak && (drop_sh < peak_k);
        abs_hit      = drop < $signed(DROP_W'({safe_thresh_reg, {FRAC_W{1'b0}}}));
        ticks_inc    = (ticks_reg != TICK_MAX) ? ticks_reg + 1'b1 : ticks_reg;
        timeout_hit  = CNT_W'(ticks_inc) >= CNT_W'(timeout_reg);
        cd_wide       = CNT_W'(cooldown_reg);
        tick_max_wide = CNT_W'(TICK_MAX);
        cd_sat       = (cd_wide > tick_max_wide) ? TICK_MAX : cd_wide[TICK_WIDTH-1:0];
    end

    // state update
    always_comb begin
        seeded_next      = seeded_reg;
        baseline_next    = baseline_reg;
        prev_next        = prev_reg;
        peak_next        = peak_reg;
        armed_next       = armed_reg;
        cool_next        = cool_reg;
        ticks_next       = ticks_reg;
        shots_total_next = shots_total_reg;
        shot_next        = 1'b0;
        if (!seeded_reg) begin
            // first item seeds only
            seeded_next   = 1'b1;
            baseline_next = val;
            prev_next     = mag_reg;
            peak_next     = '0;
            cool_next     = '0;
        end else begin
            baseline_next = base_upd;
            prev_next     = mag_reg;
            if (cool_reg != '0) begin
                cool_next  = cool_reg - 1'b1;
                armed_next = 1'b0;
            end else if (!armed_reg) begin
                if (arm_hit) begin
                    armed_next = 1'b1;
                    peak_next  = drop;
                    ticks_next = '0;
                end
            end else begin
                ticks_next = ticks_inc;
                peak_next  = drop_gt_peak ? drop : peak_reg;
                if (rel_hit || abs_hit) begin
                    armed_next       = 1'b0;
                    shots_total_next = shots_total_reg + 1'b1;
                    cool_next        = cd_sat;
                    peak_next        = '0;
                    shot_next        = 1'b1;
                end else if (timeout_hit) begin
                    armed_next = 1'b0;
                    peak_next  = '0;
                end
            end
        end
    end

    // settings port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_gain_reg   <= 17'd6554;
            fall_gain_reg   <= 17'd655;
            fire_thresh_reg <= 16'd400;
            min_slope_reg   <= 16'd20;
            recover_reg     <= 16'd32768;
            safe_thresh_reg <= 16'd100;
            cooldown_reg    <= 16'd20;
            timeout_reg     <= 16'd200;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RISE_GAIN:    rise_gain_reg   <= cfg_wdata;
                CFG_FALL_GAIN:    fall_gain_reg   <= cfg_wdata;
                CFG_FIRE_THRESH:  fire_thresh_reg <= cfg_wdata[15:0];
                CFG_MIN_SLOPE:    min_slope_reg   <= cfg_wdata[15:0];
                CFG_RECOVER_FRAC: recover_reg     <= cfg_wdata[15:0];
                CFG_SAFE_THRESH:  safe_thresh_reg <= cfg_wdata[15:0];
                CFG_COOLDOWN:     cooldown_reg    <= cfg_wdata[15:0];
                CFG_TIMEOUT:      timeout_reg     <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_v_reg <= 1'b1;
        end else if (advance) begin
            in_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mag_reg <= mag_next;
        end
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg       <= 1'b0;
            seeded_reg      <= 1'b0;
            baseline_reg    <= '0;
            prev_reg        <= '0;
            peak_reg        <= '0;
            armed_reg       <= 1'b0;
            cool_reg        <= '0;
            ticks_reg       <= '0;
            shots_total_reg <= '0;
        end else begin
            if (advance) begin
                out_v_reg       <= 1'b1;
                seeded_reg      <= seeded_next;
                baseline_reg    <= baseline_next;
                prev_reg        <= prev_next;
                peak_reg        <= peak_next;
                armed_reg       <= armed_next;
                cool_reg        <= cool_next;
                ticks_reg       <= ticks_next;
                shots_total_reg <= shots_total_next;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg.shot_detected <= shot_next;
            out_reg.shot_count    <= shots_total_next;
        end
    end

    // checks
    `FSDD_ASSERT_NEXT(a_count_step, aclk, aresetn, advance, m_item.shot_count == $past(shots_total_reg) + COUNT_W'($past(shot_next)))
    `FSDD_ASSERT_IMPLIES(a_armed_no_cool, aclk, aresetn, armed_reg, cool_reg == '0)
    `FSDD_ASSERT_IMPLIES(a_unseeded_idle, aclk, aresetn, !seeded_reg, !armed_reg && shots_total_reg == '0)

endmodule
